// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the service table parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SDTP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define SDTP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define SDTP_ASSERT(lbl, clk, rst_n, prop)
`define SDTP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/sdtp_pkg.sv -----
// Types and constants of the service table section parser.
package sdtp_pkg;

  typedef enum logic [1:0] {
    PH_NET  = 2'd0,
    PH_HEAD = 2'd1,
    PH_DESC = 2'd2,
    PH_DROP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_DESC    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_TRUNC   = 2'd2
  } status_e;

  localparam logic [7:0] MAX_SERVICES_RST = 8'd128;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = 2;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned LIMIT_W = 9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } sdtp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] network_id;
    logic [6:0]  service_index;
    logic [15:0] svc_ident;
    logic        eit_sched;
    logic        eit_present_following;
    logic [2:0]  run_state;
    logic        ca_mode;
    logic [11:0] descriptor_length;
    logic [7:0]  descriptor_byte;
    logic [7:0]  service_count;
    logic [1:0]  status;
  } sdtp_out_t;

  // Up to two results produced by one byte, in order.
  typedef struct packed {
    logic [1:0] n;
    sdtp_out_t  r0;
    sdtp_out_t  r1;
  } sdtp_push_t;

endpackage

// ----- rtl/service_table_section_parser.sv -----
// Top level of the service description section body parser.
//
// Input channel (in_valid_i / in_stall_o / in_i): one section body byte per
// transaction, starting after the section header, with last set on the
// final body byte. Output channel (out_valid_o / out_stall_i / out_o): one
// result per transaction: a service entry, a descriptor byte, or the
// end-of-section summary with service count and status.
// Configuration: cfg_we_i writes cfg_wdata_i to max_services; write only
// while idle. Reset value 128.
// An accepted byte is held in the input register until the parse logic
// writes its results into the result queue, which feeds the output.
// Throughput: one byte per cycle while the queue has room for two results.
// A last byte that also yields an entry or descriptor result produces two
// results; the four-entry result queue absorbs them, the output drains one
// per cycle while the receiver does not stall. When the receiver stalls,
// the queue fills and then in_stall_o rises; nothing is dropped. Reset
// clears all parse state and empties the queue.
`include "assert_macros.svh"
module service_table_section_parser #(
  parameter int unsigned SERVICE_LIMIT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdtp_pkg::sdtp_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdtp_pkg::sdtp_out_t out_o
);

  logic [7:0]          max_q;
  logic                s1_valid_q, s1_valid_d;
  sdtp_pkg::sdtp_in_t  s1_q;
  logic                room;
  logic                go;
  logic                in_take;
  sdtp_pkg::sdtp_push_t push;

  // Byte leaves the input register when the queue can take two results.
  assign go         = s1_valid_q & room;
  assign in_stall_o = s1_valid_q & ~room;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_take | (s1_valid_q & ~go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q      <= sdtp_pkg::MAX_SERVICES_RST;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      s1_valid_q <= s1_valid_d;
    end
  end

  // Input payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_i;
    end
  end

  sdtp_parse #(
    .SERVICE_LIMIT(SERVICE_LIMIT)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (go),
    .in_i          (s1_q),
    .max_services_i(max_q),
    .push_o        (push)
  );

  sdtp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  // A held byte stays in the input register until the queue has room.
  `SDTP_ASSERT(a_hold_s1, clk_i, rst_ni, (s1_valid_q && !room) |=> s1_valid_q)

endmodule

// ----- rtl/sdtp_parse.sv -----
// Section body parsing state and per-byte result generation.
`include "assert_macros.svh"
module sdtp_parse #(
  parameter int unsigned SERVICE_LIMIT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  sdtp_pkg::sdtp_in_t  in_i,
  input  logic [7:0]          max_services_i,
  output sdtp_pkg::sdtp_push_t push_o
);

  sdtp_pkg::phase_e phase_q, phase_d;
  logic [2:0]  bp_q, bp_d;
  logic [11:0] rem_q, rem_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] nw_q, nw_d;
  logic [31:0] hb_q, hb_d;
  logic        ovf_q, ovf_d;

  logic [sdtp_pkg::LIMIT_W-1:0] limit;
  logic [11:0] dlen;
  logic        has_a;
  logic        cut;
  sdtp_pkg::sdtp_out_t res_a, res_s;

  assign limit = ({1'b0, max_services_i} < sdtp_pkg::LIMIT_W'(SERVICE_LIMIT)) ?
                 {1'b0, max_services_i} : sdtp_pkg::LIMIT_W'(SERVICE_LIMIT);
  assign dlen  = {hb_q[3:0], in_i.data_byte};

  always_comb begin
    phase_d = phase_q;
    bp_d    = bp_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    nw_d    = nw_q;
    hb_d    = hb_q;
    ovf_d   = ovf_q;
    has_a   = 1'b0;
    res_a   = '0;
    res_s   = '0;
    cut     = 1'b0;
    push_o  = '0;
    if (go_i) begin
      case (phase_q)
        sdtp_pkg::PH_NET: begin
          if (bp_q < 3'd2) begin
            nw_d = {nw_q[7:0], in_i.data_byte};
          end
          bp_d = bp_q + 3'd1;
          if (bp_q == 3'd2) begin
            phase_d = sdtp_pkg::PH_HEAD;
            bp_d    = '0;
          end
        end
        sdtp_pkg::PH_HEAD: begin
          if (bp_q == 3'd0 && {1'b0, cnt_q} >= limit) begin
            phase_d = sdtp_pkg::PH_DROP;
            ovf_d   = 1'b1;
          end else if (bp_q < 3'd4) begin
            hb_d = {hb_q[23:0], in_i.data_byte};
            bp_d = bp_q + 3'd1;
          end else begin
            has_a                       = 1'b1;
            res_a.kind                  = sdtp_pkg::KIND_ENTRY;
            res_a.service_index         = cnt_q[6:0];
            res_a.svc_ident             = hb_q[31:16];
            res_a.eit_sched             = hb_q[9];
            res_a.eit_present_following = hb_q[8];
            res_a.run_state             = hb_q[7:5];
            res_a.ca_mode               = hb_q[4];
            res_a.descriptor_length     = dlen;
            cnt_d = cnt_q + 8'd1;
            bp_d  = '0;
            hb_d  = '0;
            if (dlen != 12'd0) begin
              phase_d = sdtp_pkg::PH_DESC;
              rem_d   = dlen;
            end
          end
        end
        sdtp_pkg::PH_DESC: begin
          has_a                 = 1'b1;
          res_a.kind            = sdtp_pkg::KIND_DESC;
          res_a.service_index   = 7'(cnt_q - 8'd1);
          res_a.descriptor_byte = in_i.data_byte;
          rem_d = rem_q - 12'd1;
          if (rem_d == 12'd0) begin
            phase_d = sdtp_pkg::PH_HEAD;
            bp_d    = '0;
          end
        end
        default: begin
        end
      endcase
      res_a.network_id = nw_d;

      // Section end: summary follows any entry/descriptor result of this byte.
      cut = (phase_d == sdtp_pkg::PH_NET) || (phase_d == sdtp_pkg::PH_DESC) ||
            (phase_d == sdtp_pkg::PH_HEAD && bp_d != 3'd0);
      res_s.kind          = sdtp_pkg::KIND_SUMMARY;
      res_s.network_id    = nw_d;
      res_s.service_count = cnt_d;
      res_s.status        = cut ? sdtp_pkg::ST_TRUNC :
                            (ovf_d ? sdtp_pkg::ST_DROPPED : sdtp_pkg::ST_OK);

      if (has_a) begin
        push_o.r0 = res_a;
        push_o.r1 = res_s;
        push_o.n  = in_i.last ? 2'd2 : 2'd1;
      end else begin
        push_o.r0 = res_s;
        push_o.n  = in_i.last ? 2'd1 : 2'd0;
      end

      if (in_i.last) begin
        phase_d = sdtp_pkg::PH_NET;
        bp_d    = '0;
        rem_d   = '0;
        cnt_d   = '0;
        nw_d    = '0;
        hb_d    = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdtp_pkg::PH_NET;
      bp_q    <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      nw_q    <= '0;
      hb_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bp_q    <= bp_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      nw_q    <= nw_d;
      hb_q    <= hb_d;
      ovf_q   <= ovf_d;
    end
  end

  `SDTP_ASSERT(a_desc_nonzero, clk_i, rst_ni, (phase_q == sdtp_pkg::PH_DESC) |-> (rem_q != 12'd0))
  `SDTP_ASSERT(a_end_rearm, clk_i, rst_ni, go_i && in_i.last |=> phase_q == sdtp_pkg::PH_NET)
  `SDTP_ASSERT(a_drop_flag, clk_i, rst_ni, (phase_q == sdtp_pkg::PH_DROP) |-> ovf_q)

endmodule

// ----- rtl/sdtp_fifo.sv -----
// Result queue taking up to two results per cycle and giving one per cycle unless the output is stalled.
`include "assert_macros.svh"
module sdtp_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdtp_pkg::sdtp_push_t push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sdtp_pkg::sdtp_out_t  out_o
);

  sdtp_pkg::sdtp_out_t mem [sdtp_pkg::FIFO_DEPTH];
  logic [sdtp_pkg::PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [sdtp_pkg::CNT_W-1:0] count_q, count_d;
  logic                       pop;

  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = count_q != '0;
  assign out_o       = mem[rd_q];
  assign room_o      = count_q <= sdtp_pkg::CNT_W'(sdtp_pkg::FIFO_DEPTH - 2);

  always_comb begin
    wr_d    = wr_q + sdtp_pkg::PTR_W'(push_i.n);
    rd_d    = rd_q + sdtp_pkg::PTR_W'(pop);
    count_d = count_q + sdtp_pkg::CNT_W'(push_i.n) - sdtp_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem[wr_q + sdtp_pkg::PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  `SDTP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= sdtp_pkg::CNT_W'(sdtp_pkg::FIFO_DEPTH))
  `SDTP_ASSERT(a_push_room, clk_i, rst_ni, (push_i.n != 2'd0) |-> room_o)

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the service description section body parser.
`timescale 1ns / 100ps

module tb;

  // Entry cap built into the block, passed down explicitly.
  localparam int unsigned SVC_CAP = 128;
  // Cycles without any transaction before the run is declared hung. The
  // long receiver hold plus the slowest drain stays far below this.
  localparam int WATCHDOG_LIMIT = 4000;
  // Receiver hold-off that lets the result queue fill and back up the input.
  localparam int HOLD_CYCLES = 300;
  // Quiet cycles after the last result: the byte pipe is two stages deep.
  localparam int SETTLE_CYCLES = 6;
  // Random bytes per settings step; the section in progress runs over, and
  // one large section comes on top.
  localparam int STEP_BYTES = 60;
  localparam int DIR_ROWS = 28;

  // One row of the directed table. Where typed is set, the section summary
  // of that byte is checked against cnt/st as written here.
  typedef struct {
    logic [7:0]        data;
    logic              lst;
    bit                cfg_wr;
    logic [7:0]        cfg_val;
    bit                typed;
    logic [7:0]        cnt;
    sdtp_pkg::status_e st;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sdtp_pkg::sdtp_in_t  in_pkt = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sdtp_pkg::sdtp_out_t out_pkt;

  service_table_section_parser #(
    .SERVICE_LIMIT(SVC_CAP)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_pkt),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_pkt)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Section parser prediction: own copy of the parse state and register.
  // ---------------------------------------------------------------------
  sdtp_pkg::phase_e ph;
  logic [2:0]  byte_pos;
  logic [11:0] desc_left;
  logic [7:0]  svc_cnt;
  logic [15:0] net_word;
  logic [31:0] hdr;
  bit          dropped;
  logic [7:0]  max_svc = sdtp_pkg::MAX_SERVICES_RST;

  sdtp_pkg::sdtp_out_t expect_q[$];   // predicted results, oldest first

  int tx_idle_pct = 0;        // percent of cycles the byte source holds back
  int rx_idle_pct = 0;        // percent of cycles the result sink stalls
  bit hold_req = 1'b0;        // asks the sink for one long hold-off
  int bytes_sent = 0;
  int fails = 0;
  int quiet = 0;

  logic [7:0] sec_bytes[$];   // section under construction

  // Back to the start of a section; the register is kept.
  function automatic void clear_section();
    ph = sdtp_pkg::PH_NET;
    byte_pos = '0;
    desc_left = '0;
    svc_cnt = '0;
    net_word = '0;
    hdr = '0;
    dropped = 1'b0;
  endfunction

  function automatic sdtp_pkg::sdtp_out_t blank_result(sdtp_pkg::kind_e k);
    sdtp_pkg::sdtp_out_t r;
    r = '0;
    r.kind = k;
    r.network_id = net_word;
    return r;
  endfunction

  // Advance the prediction by one accepted body byte and queue what it yields.
  task automatic parse_byte(input logic [7:0] b, input logic lst);
    sdtp_pkg::sdtp_out_t res;
    logic [8:0]  cap;
    logic [11:0] dlen;
    bit          cut;
    cap = (max_svc < SVC_CAP) ? 9'(max_svc) : 9'(SVC_CAP);
    case (ph)
      sdtp_pkg::PH_NET: begin
        // two id bytes, then the reserved byte is skipped
        if (byte_pos < 3'd2) net_word = {net_word[7:0], b};
        byte_pos = byte_pos + 3'd1;
        if (byte_pos >= 3'd3) begin
          ph = sdtp_pkg::PH_HEAD;
          byte_pos = '0;
        end
      end
      sdtp_pkg::PH_HEAD: begin
        if (byte_pos == 3'd0 && 9'(svc_cnt) >= cap) begin
          // limit hit at an entry boundary: drop the rest of the section
          ph = sdtp_pkg::PH_DROP;
          dropped = 1'b1;
        end else if (byte_pos < 3'd4) begin
          hdr = {hdr[23:0], b};
          byte_pos = byte_pos + 3'd1;
        end else begin
          // fifth header byte: hdr holds id hi/lo, flags, status byte
          dlen = {hdr[3:0], b};
          res = blank_result(sdtp_pkg::KIND_ENTRY);
          res.service_index = svc_cnt[6:0];
          res.svc_ident = hdr[31:16];
          res.eit_sched = hdr[9];
          res.eit_present_following = hdr[8];
          res.run_state = hdr[7:5];
          res.ca_mode = hdr[4];
          res.descriptor_length = dlen;
          expect_q.push_back(res);
          svc_cnt = svc_cnt + 8'd1;
          byte_pos = '0;
          hdr = '0;
          if (dlen != 12'd0) begin
            ph = sdtp_pkg::PH_DESC;
            desc_left = dlen;
          end
        end
      end
      sdtp_pkg::PH_DESC: begin
        res = blank_result(sdtp_pkg::KIND_DESC);
        res.service_index = 7'(svc_cnt - 8'd1);
        res.descriptor_byte = b;
        expect_q.push_back(res);
        desc_left = desc_left - 12'd1;
        if (desc_left == 12'd0) begin
          ph = sdtp_pkg::PH_HEAD;
          byte_pos = '0;
        end
      end
      default: ;
    endcase
    if (lst) begin
      // truncation outranks the dropped-entries status
      cut = (ph == sdtp_pkg::PH_NET) || (ph == sdtp_pkg::PH_DESC) ||
            (ph == sdtp_pkg::PH_HEAD && byte_pos != 3'd0);
      res = blank_result(sdtp_pkg::KIND_SUMMARY);
      res.service_count = svc_cnt;
      res.status = cut ? sdtp_pkg::ST_TRUNC :
                   (dropped ? sdtp_pkg::ST_DROPPED : sdtp_pkg::ST_OK);
      expect_q.push_back(res);
      clear_section();
    end
  endtask

  function automatic string show(sdtp_pkg::sdtp_out_t r);
    return $sformatf({"kind=%0d net=%h idx=%0d sid=%h eit_s=%0d eit_pf=%0d rs=%0d ",
                      "fca=%0d dlen=%0d db=%h cnt=%0d st=%0d"},
                     r.kind, r.network_id, r.service_index, r.svc_ident,
                     r.eit_sched, r.eit_present_following, r.run_state,
                     r.ca_mode, r.descriptor_length, r.descriptor_byte,
                     r.service_count, r.status);
  endfunction

  // ---------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------
  // Offers one byte, with random gaps in front, and returns at the edge the
  // transaction completes. Valid is left high so a following byte can go
  // out back to back.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pkt <= '{data_byte: b, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, lst);
    bytes_sent++;
  endtask

  // Drop valid, wait until every predicted result has come back, then let the
  // pipe run empty so that no byte is still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_services(input logic [7:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_svc = v;
  endtask

  // Builds one section in sec_bytes. forced >= 0 asks for that many entries,
  // all without descriptors and cleanly ended. Otherwise most sections are
  // well formed with random content; some are noise, cut short, or padded
  // with stray bytes after the last entry.
  task automatic make_section(input int forced);
    int sel;
    int n_ent;
    int dlen;
    int keep;
    int pick;
    sec_bytes.delete();
    sel = $urandom_range(0, 99);
    if (forced < 0 && sel < 10) begin
      repeat ($urandom_range(1, 8)) sec_bytes.push_back(8'($urandom));
    end else begin
      repeat (3) sec_bytes.push_back(8'($urandom));
      n_ent = (forced >= 0) ? forced : $urandom_range(0, 6);
      repeat (n_ent) begin
        pick = $urandom_range(0, 99);
        if (forced >= 0) dlen = 0;
        else if (pick < 80) dlen = $urandom_range(0, 5);
        else if (pick < 98) dlen = $urandom_range(6, 40);
        else dlen = $urandom_range(41, 300);
        repeat (3) sec_bytes.push_back(8'($urandom));
        sec_bytes.push_back({4'($urandom), 4'(dlen >> 8)});
        sec_bytes.push_back(8'(dlen));
        repeat (dlen) sec_bytes.push_back(8'($urandom));
      end
      if (forced < 0) begin
        if (sel < 25 && sec_bytes.size() > 1) begin
          keep = $urandom_range(1, sec_bytes.size() - 1);
          while (sec_bytes.size() > keep) void'(sec_bytes.pop_back());
        end else if (sel < 40) begin
          repeat ($urandom_range(1, 4)) sec_bytes.push_back(8'($urandom));
        end
      end
    end
  endtask

  task automatic send_section();
    foreach (sec_bytes[i]) send_byte(sec_bytes[i], i == sec_bytes.size() - 1);
  endtask

  // Directed sections, all at the reset limit except the last one:
  //   cut inside the network id;
  //   one entry with all-ones fields and two descriptor bytes, last on the
  //     final descriptor byte (descriptor and summary from one byte);
  //   header whose fifth byte is last, announcing 4095 descriptor bytes;
  //   partial header at the end;
  //   limit of zero, every entry dropped.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b1, 8'd0, sdtp_pkg::ST_TRUNC},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hF0, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b1, 8'd1, sdtp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h0F, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b1, 8'd1, sdtp_pkg::ST_TRUNC},
    '{8'h12, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h34, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h56, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'hAB, 1'b1, 1'b0, 8'h00, 1'b1, 8'd0, sdtp_pkg::ST_TRUNC},
    '{8'hAA, 1'b0, 1'b1, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h47, 1'b0, 1'b0, 8'h00, 1'b0, 8'd0, sdtp_pkg::ST_OK},
    '{8'h11, 1'b1, 1'b0, 8'h00, 1'b1, 8'd0, sdtp_pkg::ST_DROPPED}
  };

  // Settings steps: two per idling phase. Limits cover the extremes, the
  // clamp above the built-in cap and a small random one.
  int idle_tx [3] = '{32, 81, 0};
  int idle_rx [3] = '{81, 32, 0};

  initial begin : stimulus
    sdtp_pkg::sdtp_out_t summary;
    dir_row_t   row;
    logic [7:0] cfg_plan [6];
    int         target;
    cfg_plan = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd3, 8'($urandom_range(2, 20))};
    clear_section();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Typed rows replace the predicted summary fields.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      if (row.cfg_wr) write_max_services(row.cfg_val);
      send_byte(row.data, row.lst);
      if (row.typed) begin
        summary = expect_q.pop_back();
        summary.service_count = row.cnt;
        summary.status = row.st;
        expect_q.push_back(summary);
      end
    end

    // Random sections across the idling phases and limit settings.
    for (int step = 0; step < 6; step++) begin
      tx_idle_pct = idle_tx[step / 2];
      rx_idle_pct = idle_rx[step / 2];
      write_max_services(cfg_plan[step]);
      // long sink hold while bytes keep coming, with no idling otherwise
      if (step == 4) hold_req = 1'b1;
      // fill the full entry range at the built-in cap: indexes up to 127,
      // count 128, then the surplus entries dropped
      if (step == 3) begin
        make_section(SVC_CAP + 2);
        send_section();
      end
      target = bytes_sent + STEP_BYTES;
      while (bytes_sent < target) begin
        make_section(-1);
        send_section();
      end
    end

    settle();
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    sdtp_pkg::sdtp_out_t want;
    string     bad;
    if (rst_n && out_valid && !out_stall) begin
      if (expect_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result: %s", show(out_pkt));
      end else begin
        want = expect_q.pop_front();
        bad = "";
        if (out_pkt.kind !== want.kind) bad = {bad, " kind"};
        if (out_pkt.network_id !== want.network_id) bad = {bad, " network_id"};
        if (out_pkt.service_index !== want.service_index) bad = {bad, " service_index"};
        if (out_pkt.svc_ident !== want.svc_ident) bad = {bad, " svc_ident"};
        if (out_pkt.eit_sched !== want.eit_sched) bad = {bad, " eit_sched"};
        if (out_pkt.eit_present_following !== want.eit_present_following)
          bad = {bad, " eit_present_following"};
        if (out_pkt.run_state !== want.run_state) bad = {bad, " run_state"};
        if (out_pkt.ca_mode !== want.ca_mode) bad = {bad, " ca_mode"};
        if (out_pkt.descriptor_length !== want.descriptor_length)
          bad = {bad, " descriptor_length"};
        if (out_pkt.descriptor_byte !== want.descriptor_byte) bad = {bad, " descriptor_byte"};
        if (out_pkt.service_count !== want.service_count) bad = {bad, " service_count"};
        if (out_pkt.status !== want.status) bad = {bad, " status"};
        if (bad != "") begin
          fails++;
          if (fails <= 10) begin
            $display("mismatch in%s", bad);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(out_pkt));
          end
        end
      end
    end
  end

  // Hang detection: any transaction on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
